/* src/jjy_pkg.sv */
// Package for the JJY time code decoder: state, operation and code types,
// the decode step table and the calendar table. Depends on nothing.
package jjy_pkg;

  localparam int LastSec  = 59;
  localparam int DecSteps = 40;
  localparam logic [6:0] UNSYNC = 7'd127;

  typedef enum logic [3:0] {
    S_IDLE, S_CLS0, S_CLS1, S_CLS2, S_GAP, S_EVAL, S_DEC, S_CHK, S_MON, S_FIN
  } state_t;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_ABSLE} alu_op_t;

  typedef enum logic [1:0] {SYM_ZERO, SYM_ONE, SYM_MARK, SYM_BAD} sym_t;

  typedef enum logic [2:0] {
    REG_ZERO_DIP, REG_ONE_DIP, REG_MARKER_DIP, REG_DIP_TOL, REG_GAP, REG_GAP_TOL
  } cfg_reg_t;

  typedef enum logic [3:0] {
    F_MIN, F_HOUR, F_DOY, F_YEAR, F_WDAY, F_PA1, F_PA2, F_B38, F_B40, F_B53, F_B54
  } field_t;

  localparam logic [1:0] KIND_BIT  = 2'd0;
  localparam logic [1:0] KIND_TIME = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [1:0] BIT_ZERO = 2'd0;
  localparam logic [1:0] BIT_ONE  = 2'd1;
  localparam logic [1:0] BIT_NONE = 2'd2;

  localparam logic [2:0] ERR_EARLY      = 3'd0;
  localparam logic [2:0] ERR_SKIPPED    = 3'd1;
  localparam logic [2:0] ERR_OVERRUN    = 3'd2;
  localparam logic [2:0] ERR_PATTERN    = 3'd3;
  localparam logic [2:0] ERR_INCOMPLETE = 3'd4;
  localparam logic [2:0] ERR_PA1        = 3'd5;
  localparam logic [2:0] ERR_PA2        = 3'd6;
  localparam logic [2:0] ERR_RANGE      = 3'd7;

  typedef struct packed {
    logic [5:0] addr;
    logic [7:0] weight;
    field_t     field;
  } step_t;

  typedef struct packed {
    logic       wr_en;
    logic [5:0] wr_addr;
    logic       wr_bit;
    logic [5:0] rd_addr;
    logic       clear;
  } frame_ctl_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [5:0] second_index;
    logic [1:0] bit_value;
    logic [2:0] error_code;
    logic [5:0] minute_value;
    logic [4:0] hour_value;
    logic       date_valid;
    logic [6:0] year_two_digit;
    logic [3:0] month_value;
    logic [4:0] day_value;
    logic [2:0] weekday_value;
    logic [3:0] flag_bits;
  } result_t;

  function automatic step_t dec_step(input logic [5:0] k);
    step_t s;
    case (k)
      6'd0:  s = '{6'd1,  8'd40,  F_MIN};
      6'd1:  s = '{6'd2,  8'd20,  F_MIN};
      6'd2:  s = '{6'd3,  8'd10,  F_MIN};
      6'd3:  s = '{6'd5,  8'd8,   F_MIN};
      6'd4:  s = '{6'd6,  8'd4,   F_MIN};
      6'd5:  s = '{6'd7,  8'd2,   F_MIN};
      6'd6:  s = '{6'd8,  8'd1,   F_MIN};
      6'd7:  s = '{6'd12, 8'd20,  F_HOUR};
      6'd8:  s = '{6'd13, 8'd10,  F_HOUR};
      6'd9:  s = '{6'd15, 8'd8,   F_HOUR};
      6'd10: s = '{6'd16, 8'd4,   F_HOUR};
      6'd11: s = '{6'd17, 8'd2,   F_HOUR};
      6'd12: s = '{6'd18, 8'd1,   F_HOUR};
      6'd13: s = '{6'd22, 8'd200, F_DOY};
      6'd14: s = '{6'd23, 8'd100, F_DOY};
      6'd15: s = '{6'd25, 8'd80,  F_DOY};
      6'd16: s = '{6'd26, 8'd40,  F_DOY};
      6'd17: s = '{6'd27, 8'd20,  F_DOY};
      6'd18: s = '{6'd28, 8'd10,  F_DOY};
      6'd19: s = '{6'd30, 8'd8,   F_DOY};
      6'd20: s = '{6'd31, 8'd4,   F_DOY};
      6'd21: s = '{6'd32, 8'd2,   F_DOY};
      6'd22: s = '{6'd33, 8'd1,   F_DOY};
      6'd23: s = '{6'd41, 8'd80,  F_YEAR};
      6'd24: s = '{6'd42, 8'd40,  F_YEAR};
      6'd25: s = '{6'd43, 8'd20,  F_YEAR};
      6'd26: s = '{6'd44, 8'd10,  F_YEAR};
      6'd27: s = '{6'd45, 8'd8,   F_YEAR};
      6'd28: s = '{6'd46, 8'd4,   F_YEAR};
      6'd29: s = '{6'd47, 8'd2,   F_YEAR};
      6'd30: s = '{6'd48, 8'd1,   F_YEAR};
      6'd31: s = '{6'd50, 8'd4,   F_WDAY};
      6'd32: s = '{6'd51, 8'd2,   F_WDAY};
      6'd33: s = '{6'd52, 8'd1,   F_WDAY};
      6'd34: s = '{6'd36, 8'd0,   F_PA1};
      6'd35: s = '{6'd37, 8'd0,   F_PA2};
      6'd36: s = '{6'd38, 8'd0,   F_B38};
      6'd37: s = '{6'd40, 8'd0,   F_B40};
      6'd38: s = '{6'd53, 8'd0,   F_B53};
      default: s = '{6'd54, 8'd0, F_B54};
    endcase
    return s;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd1:                   d = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
      default:                d = 5'd31;
    endcase
    return d;
  endfunction

  function automatic logic marker_pos(input logic [6:0] s);
    return (s == 7'd0) || (s == 7'd9) || (s == 7'd19) || (s == 7'd29) ||
           (s == 7'd39) || (s == 7'd49) || (s == 7'd59);
  endfunction

endpackage

/* src/jjy_in_if.sv */
// Input channel of the JJY decoder: one carrier dip per request.
// Depends on nothing.
interface jjy_in_if;
  logic        valid;
  logic        ready;
  logic [10:0] dip_duration_ms;
  logic [11:0] gap_since_last_ms;

  modport source (output valid, input ready, output dip_duration_ms, gap_since_last_ms);
  modport sink   (input valid, output ready, input dip_duration_ms, gap_since_last_ms);
endinterface

/* src/jjy_out_if.sv */
// Result channel of the JJY decoder: stored bit, decoded time or error.
// Depends on nothing.
interface jjy_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [5:0] second_index;
  logic [1:0] bit_value;
  logic [2:0] error_code;
  logic [5:0] minute_value;
  logic [4:0] hour_value;
  logic       date_valid;
  logic [6:0] year_two_digit;
  logic [3:0] month_value;
  logic [4:0] day_value;
  logic [2:0] weekday_value;
  logic [3:0] flag_bits;

  modport source (output valid, input ready, output result_kind, second_index, bit_value,
                  error_code, minute_value, hour_value, date_valid, year_two_digit,
                  month_value, day_value, weekday_value, flag_bits);
  modport sink   (input valid, output ready, input result_kind, second_index, bit_value,
                  error_code, minute_value, hour_value, date_valid, year_two_digit,
                  month_value, day_value, weekday_value, flag_bits);
endinterface

/* src/jjy_cfg_if.sv */
// Configuration write channel of the JJY decoder: register index and data.
// Depends on nothing.
interface jjy_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [11:0] data;

  modport source (output valid, input ready, output index, data);
  modport sink   (input valid, output ready, input index, data);
endinterface

/* src/jjy_alu.sv */
// Shared arithmetic unit of the JJY decoder: add, subtract with compare,
// and absolute difference against a tolerance. Depends on jjy_pkg.
module jjy_alu import jjy_pkg::*; (
  input  alu_op_t     op,
  input  logic [12:0] a,
  input  logic [12:0] b,
  input  logic [9:0]  c,
  output logic [12:0] res,
  output logic        flag
);
  logic [12:0] mag;

  always_comb begin
    mag  = (a >= b) ? (a - b) : (b - a);
    res  = '0;
    flag = 1'b0;
    unique case (op)
      OP_ADD: res = a + b;
      OP_SUB: begin
        res  = a - b;
        flag = (a <= b);
      end
      OP_ABSLE: begin
        res  = mag;
        flag = (mag <= {3'b000, c});
      end
      default: res = '0;
    endcase
  end
endmodule

/* src/jjy_frame_mem.sv */
// Frame store of the JJY decoder: 60 one-bit entries with a valid bit each,
// registered read. An entry without its valid bit reads as no data. Depends on jjy_pkg.
module jjy_frame_mem import jjy_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  frame_ctl_t ctl,
  output logic [1:0] rd_bit
);
  logic        mem [60];
  logic [59:0] valid;
  logic        rd_dat;
  logic        rd_vld;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_bit;
    end
    rd_dat <= mem[ctl.rd_addr];
  end

  // Clearing the valid bits empties the whole frame.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid[ctl.wr_addr] <= 1'b1;
      end
      rd_vld <= valid[ctl.rd_addr];
    end
  end

  assign rd_bit = rd_vld ? {1'b0, rd_dat} : BIT_NONE;
endmodule

/* src/jjy_time_code_decoder.sv */
// JJY time code decoder, top level: classifies one dip per request, tracks the frame
// and decodes the minute. A dip makes four passes through the shared ALU before its
// evaluation; a minute mark ending a full frame reaches its result through 40 frame reads
// through the ALU and up to 12 month subtractions.
// One request at a time; the result register frees the input side once loaded.
// Synchronous reset restores the nominal registers, empties the frame and drops sync.
module jjy_time_code_decoder import jjy_pkg::*; (
  input logic     clk,
  input logic     rst,
  jjy_in_if.sink  in_ch,
  jjy_out_if.source out_ch,
  jjy_cfg_if.sink cfg
);
  state_t      state, state_next;
  logic [10:0] zero_nom, one_nom, mark_nom;
  logic [8:0]  dip_tol;
  logic [11:0] gap_nom;
  logic [9:0]  gap_tol;

  logic [10:0] dip;
  logic [11:0] gap;
  logic        is_zero, is_one, is_mark, gap_ok;
  logic [6:0]  cur_sec, cur_next;
  logic        prev_mark, prev_next, have_prev, have_next;

  logic [5:0]  step_k;
  logic        proc_live;
  step_t       proc_step, cur_step;
  logic [6:0]  acc_min;
  logic [5:0]  acc_hour;
  logic [8:0]  acc_doy;
  logic [7:0]  acc_year;
  logic [2:0]  acc_wday;
  logic [4:0]  miss;
  logic        par_min, par_hour;
  logic [1:0]  sv_pa1, sv_pa2, sv_38, sv_40, sv_53, sv_54;
  logic [8:0]  rem;
  logic [3:0]  mon;
  logic        leap, d_valid;
  logic [3:0]  d_mon;
  logic [4:0]  d_day;

  logic        out_valid, out_load, out_free;
  result_t     res_q, res_next;
  frame_ctl_t  ctl;
  logic [1:0]  rd_bit;

  alu_op_t     alu_op;
  logic [12:0] alu_a, alu_b, alu_res;
  logic [9:0]  alu_c;
  logic        alu_flag;

  sym_t        sym;
  logic        is_m, minute_hit;
  logic [6:0]  nxt;
  logic        pa1_bad, pa2_bad, date_ok;
  logic [4:0]  dim;

  jjy_alu u_alu (
    .op(alu_op), .a(alu_a), .b(alu_b), .c(alu_c), .res(alu_res), .flag(alu_flag)
  );

  jjy_frame_mem u_frame (.clk(clk), .rst(rst), .ctl(ctl), .rd_bit(rd_bit));

  assign in_ch.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign out_free    = !out_valid || out_ch.ready;

  always_comb begin
    if (is_zero)      sym = SYM_ZERO;
    else if (is_one)  sym = SYM_ONE;
    else if (is_mark) sym = SYM_MARK;
    else              sym = SYM_BAD;
  end

  assign is_m       = (sym == SYM_MARK);
  assign minute_hit = have_prev && is_m && prev_mark && gap_ok;
  assign nxt        = cur_sec + 7'd1;
  assign cur_step   = dec_step(step_k);
  assign dim        = month_days(mon) + {4'd0, (mon == 4'd1) && leap};
  assign pa1_bad    = miss[1] || (sv_pa1 == BIT_NONE) || (par_hour ^ sv_pa1[0]);
  assign pa2_bad    = miss[0] || (sv_pa2 == BIT_NONE) || (par_min ^ sv_pa2[0]);
  assign date_ok    = !miss[2] && !miss[3] && !miss[4] && (acc_doy >= 9'd1) &&
                      (acc_doy <= 9'd366) && (acc_year <= 8'd99) && (acc_wday <= 3'd6);

  // Operand selection for the shared ALU.
  always_comb begin
    alu_op = OP_ADD;
    alu_a  = '0;
    alu_b  = '0;
    alu_c  = '0;
    unique case (state)
      S_CLS0, S_CLS1, S_CLS2: begin
        alu_op = OP_ABSLE;
        alu_a  = {2'b00, dip};
        alu_c  = {1'b0, dip_tol};
        if (state == S_CLS0)      alu_b = {2'b00, zero_nom};
        else if (state == S_CLS1) alu_b = {2'b00, one_nom};
        else                      alu_b = {2'b00, mark_nom};
      end
      S_GAP: begin
        alu_op = OP_ABSLE;
        alu_a  = {1'b0, gap};
        alu_b  = {1'b0, gap_nom};
        alu_c  = gap_tol;
      end
      S_DEC: begin
        alu_b = (rd_bit == BIT_ONE) ? {5'd0, proc_step.weight} : 13'd0;
        case (proc_step.field)
          F_MIN:   alu_a = {6'd0, acc_min};
          F_HOUR:  alu_a = {7'd0, acc_hour};
          F_DOY:   alu_a = {4'd0, acc_doy};
          F_YEAR:  alu_a = {5'd0, acc_year};
          F_WDAY:  alu_a = {10'd0, acc_wday};
          default: alu_a = '0;
        endcase
      end
      S_MON: begin
        alu_op = OP_SUB;
        alu_a  = {4'd0, rem};
        alu_b  = {8'd0, dim};
      end
      default: alu_op = OP_ADD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    out_load    = 1'b0;
    res_next    = '0;
    cur_next    = cur_sec;
    prev_next   = prev_mark;
    have_next   = have_prev;
    ctl.wr_en   = 1'b0;
    ctl.wr_addr = nxt[5:0];
    ctl.wr_bit  = (sym == SYM_ONE);
    ctl.rd_addr = cur_step.addr;
    ctl.clear   = 1'b0;
    unique case (state)
      S_IDLE: if (in_ch.valid) state_next = S_CLS0;
      S_CLS0: state_next = S_CLS1;
      S_CLS1: state_next = S_CLS2;
      S_CLS2: state_next = S_GAP;
      S_GAP:  state_next = S_EVAL;
      S_EVAL: begin
        if (out_free) begin
          state_next = S_IDLE;
          have_next  = 1'b1;
          prev_next  = is_m;
          if (minute_hit) begin
            if (cur_sec == 7'(LastSec)) begin
              state_next = S_DEC;
            end else begin
              if (cur_sec != UNSYNC && cur_sec != 7'd0) begin
                out_load              = 1'b1;
                res_next.result_kind  = KIND_ERR;
                res_next.second_index = cur_sec[5:0];
                res_next.error_code   = ERR_EARLY;
              end
              ctl.clear = 1'b1;
              cur_next  = 7'd0;
            end
          end else if (cur_sec > 7'(LastSec)) begin
            cur_next = UNSYNC;
          end else if (cur_sec == 7'(LastSec)) begin
            out_load              = 1'b1;
            res_next.result_kind  = KIND_ERR;
            res_next.second_index = 6'd60;
            res_next.error_code   = ERR_OVERRUN;
            ctl.clear             = 1'b1;
            cur_next              = UNSYNC;
          end else if (sym == SYM_BAD) begin
            out_load              = 1'b1;
            res_next.result_kind  = KIND_ERR;
            res_next.second_index = nxt[5:0];
            res_next.error_code   = ERR_SKIPPED;
            cur_next              = nxt;
          end else if (marker_pos(nxt) != is_m) begin
            out_load              = 1'b1;
            res_next.result_kind  = KIND_ERR;
            res_next.second_index = nxt[5:0];
            res_next.error_code   = ERR_PATTERN;
            ctl.clear             = 1'b1;
            cur_next              = UNSYNC;
          end else begin
            ctl.wr_en             = !is_m;
            out_load              = 1'b1;
            res_next.result_kind  = KIND_BIT;
            res_next.second_index = nxt[5:0];
            res_next.bit_value    = is_m ? BIT_NONE : {1'b0, sym == SYM_ONE};
            cur_next              = nxt;
          end
        end
      end
      S_DEC: begin
        if (step_k == 6'(DecSteps) && !proc_live) state_next = S_CHK;
      end
      S_CHK: begin
        if (out_free) begin
          if (miss[0] || miss[1] || pa1_bad || pa2_bad ||
              acc_min > 7'd59 || acc_hour > 6'd23) begin
            out_load             = 1'b1;
            res_next.result_kind = KIND_ERR;
            if (miss[0] || miss[1]) res_next.error_code = ERR_INCOMPLETE;
            else if (pa1_bad)       res_next.error_code = ERR_PA1;
            else if (pa2_bad)       res_next.error_code = ERR_PA2;
            else                    res_next.error_code = ERR_RANGE;
            ctl.clear  = 1'b1;
            cur_next   = 7'd0;
            state_next = S_IDLE;
          end else begin
            state_next = date_ok ? S_MON : S_FIN;
          end
        end
      end
      S_MON: begin
        if (alu_flag || mon == 4'd11) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_load              = 1'b1;
          res_next.result_kind  = KIND_TIME;
          res_next.minute_value = acc_min[5:0];
          res_next.hour_value   = acc_hour[4:0];
          if (d_valid) begin
            res_next.date_valid     = 1'b1;
            res_next.year_two_digit = acc_year[6:0];
            res_next.month_value    = d_mon;
            res_next.day_value      = d_day;
            res_next.weekday_value  = acc_wday;
          end
          res_next.flag_bits = {(sv_53 == BIT_ONE) && (sv_54 == BIT_ZERO),
                                sv_53 == BIT_ONE, sv_40 == BIT_ONE, sv_38 == BIT_ONE};
          ctl.clear  = 1'b1;
          cur_next   = 7'd0;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_nom <= 11'd200;
      one_nom  <= 11'd500;
      mark_nom <= 11'd800;
      dip_tol  <= 9'd100;
      gap_nom  <= 12'd1000;
      gap_tol  <= 10'd100;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ZERO_DIP:   zero_nom <= cfg.data[10:0];
        REG_ONE_DIP:    one_nom  <= cfg.data[10:0];
        REG_MARKER_DIP: mark_nom <= cfg.data[10:0];
        REG_DIP_TOL:    dip_tol  <= cfg.data[8:0];
        REG_GAP:        gap_nom  <= cfg.data;
        REG_GAP_TOL:    gap_tol  <= cfg.data[9:0];
        default:        gap_tol  <= gap_tol;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_sec   <= UNSYNC;
      prev_mark <= 1'b0;
      have_prev <= 1'b0;
      out_valid <= 1'b0;
      step_k    <= '0;
      proc_live <= 1'b0;
    end else begin
      cur_sec   <= cur_next;
      prev_mark <= prev_next;
      have_prev <= have_next;
      if (out_load)          out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      if (state == S_EVAL) begin
        step_k    <= '0;
        proc_live <= 1'b0;
      end else if (state == S_DEC) begin
        proc_live <= (step_k != 6'(DecSteps));
        if (step_k != 6'(DecSteps)) step_k <= step_k + 6'd1;
      end
    end
  end

  // Data path registers; the control registers above keep them in step.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      dip <= in_ch.dip_duration_ms;
      gap <= in_ch.gap_since_last_ms;
    end
    if (out_load) res_q <= res_next;
    case (state)
      S_CLS0: is_zero <= alu_flag;
      S_CLS1: is_one  <= alu_flag;
      S_CLS2: is_mark <= alu_flag;
      S_GAP:  gap_ok  <= alu_flag;
      S_EVAL: begin
        acc_min  <= '0;
        acc_hour <= '0;
        acc_doy  <= '0;
        acc_year <= '0;
        acc_wday <= '0;
        miss     <= '0;
        par_min  <= 1'b0;
        par_hour <= 1'b0;
      end
      S_DEC: begin
        if (step_k != 6'(DecSteps)) proc_step <= cur_step;
        if (proc_live) begin
          case (proc_step.field)
            F_MIN: begin
              acc_min <= alu_res[6:0];
              par_min <= par_min ^ rd_bit[0];
              if (rd_bit == BIT_NONE) miss[0] <= 1'b1;
            end
            F_HOUR: begin
              acc_hour <= alu_res[5:0];
              par_hour <= par_hour ^ rd_bit[0];
              if (rd_bit == BIT_NONE) miss[1] <= 1'b1;
            end
            F_DOY: begin
              acc_doy <= alu_res[8:0];
              if (rd_bit == BIT_NONE) miss[2] <= 1'b1;
            end
            F_YEAR: begin
              acc_year <= alu_res[7:0];
              if (rd_bit == BIT_NONE) miss[3] <= 1'b1;
            end
            F_WDAY: begin
              acc_wday <= alu_res[2:0];
              if (rd_bit == BIT_NONE) miss[4] <= 1'b1;
            end
            F_PA1:   sv_pa1 <= rd_bit;
            F_PA2:   sv_pa2 <= rd_bit;
            F_B38:   sv_38  <= rd_bit;
            F_B40:   sv_40  <= rd_bit;
            F_B53:   sv_53  <= rd_bit;
            default: sv_54  <= rd_bit;
          endcase
        end
      end
      S_CHK: begin
        rem     <= acc_doy;
        mon     <= '0;
        leap    <= (acc_year[1:0] == 2'b00);
        d_valid <= 1'b0;
      end
      S_MON: begin
        if (alu_flag) begin
          d_valid <= 1'b1;
          d_mon   <= mon + 4'd1;
          d_day   <= rem[4:0];
        end else begin
          rem <= alu_res[8:0];
          mon <= mon + 4'd1;
        end
      end
      default: rem <= rem;
    endcase
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.result_kind    = res_q.result_kind;
  assign out_ch.second_index   = res_q.second_index;
  assign out_ch.bit_value      = res_q.bit_value;
  assign out_ch.error_code     = res_q.error_code;
  assign out_ch.minute_value   = res_q.minute_value;
  assign out_ch.hour_value     = res_q.hour_value;
  assign out_ch.date_valid     = res_q.date_valid;
  assign out_ch.year_two_digit = res_q.year_two_digit;
  assign out_ch.month_value    = res_q.month_value;
  assign out_ch.day_value      = res_q.day_value;
  assign out_ch.weekday_value  = res_q.weekday_value;
  assign out_ch.flag_bits      = res_q.flag_bits;

`ifndef NO_ASSERTIONS
  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    (cur_sec <= 7'(LastSec)) || (cur_sec == UNSYNC))
    else $error("second counter outside the frame");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> state == S_CLS0)
    else $error("accepted request did not start classification");

  a_bit_second: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.result_kind == KIND_BIT |->
      out_ch.second_index != 6'd0 && out_ch.second_index <= 6'd59)
    else $error("stored bit at impossible second");

  a_overrun_pos: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.result_kind == KIND_ERR && out_ch.error_code == ERR_OVERRUN |->
      out_ch.second_index == 6'd60)
    else $error("overrun reported at wrong second");
`endif
endmodule
